[rtl/bitshuffle_4byte_elements_core_assert.svh]
// Assertion macros shared by the bit-transpose core.
`ifndef BITSHUFFLE_4BYTE_ELEMENTS_CORE_ASSERT_SVH
`define BITSHUFFLE_4BYTE_ELEMENTS_CORE_ASSERT_SVH

// Property checked on every clock edge outside of reset.
`define BS4_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define BS4_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/bs4_pkg.sv]
`timescale 1ns / 1ps

package bs4_pkg;

  // Fixed geometry of the transpose.
  localparam int GROUP_SIZE  = 16;
  localparam int POS_W       = 4;
  localparam int NUM_PLANES  = 32;
  localparam int PLANE_W     = 5;
  localparam int ELEM_W      = 32;
  localparam int WORD_W      = 16;
  localparam int OFF_W       = 14;
  localparam int CFG_W       = 13;
  localparam int QUEUE_DEPTH = 2;

  // One complete group handed from the front end to the back end.
  typedef struct packed {
    logic [GROUP_SIZE-1:0][ELEM_W-1:0] elems;
    logic [OFF_W-1:0]                  base;
    logic [OFF_W-1:0]                  stride;
  } group_t;

  // Status of the group queue as seen by its neighbors.
  typedef struct packed {
    logic full;
    logic head_valid;
  } queue_stat_t;

endpackage

[rtl/bitshuffle_4byte_elements_core.sv]
// Output: a group enters the group queue when its 16th element is accepted, and its first
// bit-plane word is then registered in the output register; the other 31 words follow one per
// cycle when the output is not stalled.
// Throughput: one element per cycle in a group, a group end waiting while the queue is full;
// the sustained rate is set by the back end, one word per unstalled cycle. A two-group queue
// decouples the sides. Reset: asynchronous, active low; clears the block counter, queue and
// output valid, and sets the element count register to 16.
`timescale 1ns / 1ps

`include "bitshuffle_4byte_elements_core_assert.svh"

module bitshuffle_4byte_elements_core #(
  parameter int MAX_ELEMS = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         num_elements_we_i,
  input  logic [bs4_pkg::CFG_W-1:0]    num_elements_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bs4_pkg::ELEM_W-1:0]   element_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bs4_pkg::OFF_W-1:0]    dest_offset_o,
  output logic [bs4_pkg::WORD_W-1:0]   plane_word_o,
  output logic                         last_o
);

  logic                  push;
  logic                  pop;
  bs4_pkg::group_t       push_data;
  bs4_pkg::group_t       head;
  bs4_pkg::queue_stat_t  q_stat;

  // Front end: gathers elements and classifies group ends.
  bs4_front #(
    .MAX_ELEMS(MAX_ELEMS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .num_elements_we_i(num_elements_we_i),
    .num_elements_i   (num_elements_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .element_i        (element_i),
    .q_stat_i         (q_stat),
    .push_o           (push),
    .push_data_o      (push_data)
  );

  // Queue of complete groups.
  bs4_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  // Back end: emits the bit planes of the head group.
  bs4_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .dest_offset_o(dest_offset_o),
    .plane_word_o (plane_word_o),
    .last_o       (last_o)
  );

  // A completed group is never offered to a full queue.
  `BS4_ASSERT_RST(a_no_overflow, clk_i, rst_ni, !(push && q_stat.full), "group pushed into full queue")
  // The back end only retires a group that is present.
  `BS4_ASSERT_RST(a_pop_valid, clk_i, rst_ni, pop |-> q_stat.head_valid, "pop from empty queue")
  // The input stalls only for lack of queue space.
  `BS4_ASSERT_RST(a_stall_cause, clk_i, rst_ni, in_stall_o |-> q_stat.full, "input stalled with queue space")
  // Retiring a group coincides with its last word entering the output register.
  `BS4_ASSERT_RST(a_pop_last, clk_i, rst_ni, pop |=> (out_valid_o && last_o), "group retired without last word")

endmodule

[rtl/bs4_front.sv]
`timescale 1ns / 1ps

module bs4_front #(
  parameter int MAX_ELEMS = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         num_elements_we_i,
  input  logic [bs4_pkg::CFG_W-1:0]    num_elements_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bs4_pkg::ELEM_W-1:0]   element_i,
  input  bs4_pkg::queue_stat_t         q_stat_i,
  output logic                         push_o,
  output bs4_pkg::group_t              push_data_o
);

  localparam int CNT_W = $clog2(MAX_ELEMS);
  localparam int N_W   = $clog2(MAX_ELEMS + 1);
  localparam int CMP_W = (N_W > bs4_pkg::CFG_W) ? N_W : bs4_pkg::CFG_W;

  logic [bs4_pkg::CFG_W-1:0]                        cfg_q;
  logic [CNT_W-1:0]                                 count_q, count_d;
  logic [bs4_pkg::GROUP_SIZE-2:0][bs4_pkg::ELEM_W-1:0] buf_q;
  logic [bs4_pkg::CFG_W-1:0]                        masked;
  logic [N_W-1:0]                                   n_eff;
  logic [N_W-1:0]                                   count_inc;
  logic [bs4_pkg::POS_W-1:0]                        pos;
  logic                                             group_end;
  logic                                             accept;

  // Element count register; the user must write it only while idle, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= bs4_pkg::CFG_W'(bs4_pkg::GROUP_SIZE);
    end else if (num_elements_we_i) begin
      cfg_q <= num_elements_i;
    end
  end

  // Effective block length: low bits dropped, zero promoted, clamped at the maximum.
  always_comb begin
    masked = {cfg_q[bs4_pkg::CFG_W-1:bs4_pkg::POS_W], {bs4_pkg::POS_W{1'b0}}};
    if (masked == '0) begin
      n_eff = N_W'(bs4_pkg::GROUP_SIZE);
    end else if (CMP_W'(masked) > CMP_W'(MAX_ELEMS)) begin
      n_eff = N_W'(MAX_ELEMS);
    end else begin
      n_eff = N_W'(masked);
    end
  end

  // Position in the group, and the stall that holds a group end for queue space.
  assign pos        = count_q[bs4_pkg::POS_W-1:0];
  assign group_end  = (pos == bs4_pkg::POS_W'(bs4_pkg::GROUP_SIZE - 1));
  assign in_stall_o = group_end && q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  // Block position counter, wrapping once it reaches the block length.
  always_comb begin
    count_inc = N_W'(count_q) + N_W'(1);
    if (count_inc >= n_eff) begin
      count_d = '0;
    end else begin
      count_d = CNT_W'(count_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // Gather the first fifteen elements of a group.
  always_ff @(posedge clk_i) begin
    if (accept && !group_end) begin
      buf_q[pos] <= element_i;
    end
  end

  // The last element completes the group, which goes straight into the queue.
  assign push_o                   = accept && group_end;
  assign push_data_o.elems        = {element_i, buf_q};
  assign push_data_o.base         = bs4_pkg::OFF_W'(count_q >> bs4_pkg::POS_W) << 1;
  assign push_data_o.stride       = bs4_pkg::OFF_W'(n_eff >> 3);

endmodule

[rtl/bs4_queue.sv]
`timescale 1ns / 1ps

module bs4_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  bs4_pkg::group_t       push_data_i,
  input  logic                  pop_i,
  output bs4_pkg::group_t       head_o,
  output bs4_pkg::queue_stat_t  stat_o
);

  localparam int PTR_W = $clog2(bs4_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(bs4_pkg::QUEUE_DEPTH + 1);

  bs4_pkg::group_t [bs4_pkg::QUEUE_DEPTH-1:0] mem_q;
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] fill_q;
  logic             do_push, do_pop;

  assign stat_o.full       = (fill_q == CNT_W'(bs4_pkg::QUEUE_DEPTH));
  assign stat_o.head_valid = (fill_q != '0);
  assign do_push           = push_i && !stat_o.full;
  assign do_pop            = pop_i && stat_o.head_valid;
  assign head_o            = mem_q[rptr_q];

  // Group storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_W'(bs4_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_W'(bs4_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/bs4_back.sv]
`timescale 1ns / 1ps

module bs4_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bs4_pkg::group_t              head_i,
  input  bs4_pkg::queue_stat_t         q_stat_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bs4_pkg::OFF_W-1:0]    dest_offset_o,
  output logic [bs4_pkg::WORD_W-1:0]   plane_word_o,
  output logic                         last_o
);

  logic [bs4_pkg::PLANE_W-1:0] plane_q;
  logic [bs4_pkg::OFF_W-1:0]   acc_q;
  logic                        out_valid_q;
  logic [bs4_pkg::OFF_W-1:0]   off_q;
  logic [bs4_pkg::WORD_W-1:0]  word_q, word_d;
  logic                        last_q;
  logic                        plane_last;
  logic                        advance;

  // A new word is formed whenever a group waits and the output register is free.
  assign advance    = q_stat_i.head_valid && (!out_valid_q || !out_stall_i);
  assign plane_last = (plane_q == bs4_pkg::PLANE_W'(bs4_pkg::NUM_PLANES - 1));
  assign pop_o      = advance && plane_last;

  // Pick bit of the current plane out of every element of the group.
  always_comb begin
    for (int e = 0; e < bs4_pkg::GROUP_SIZE; e++) begin
      word_d[e] = head_i.elems[e][plane_q];
    end
  end

  // Plane counter and running plane offset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q     <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        plane_q     <= plane_q + bs4_pkg::PLANE_W'(1);
        acc_q       <= plane_last ? '0 : acc_q + head_i.stride;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register holding the word until the transaction completes.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      off_q  <= head_i.base + acc_q;
      word_q <= word_d;
      last_q <= plane_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign dest_offset_o = off_q;
  assign plane_word_o  = word_q;
  assign last_o        = last_q;

endmodule

[verif/bitshuffle_plane_monitor.sv]
`timescale 1ns / 1ps

module bitshuffle_plane_monitor #(
  parameter int MAX_ELEMS = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         num_elements_we_i,
  input  logic [bs4_pkg::CFG_W-1:0]    num_elements_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [bs4_pkg::ELEM_W-1:0]   element_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [bs4_pkg::OFF_W-1:0]    dest_offset_i,
  input  logic [bs4_pkg::WORD_W-1:0]   plane_word_i,
  input  logic                         last_i,
  output int                           pending_o,
  output int                           mismatches_o
);

  // One bit-plane word as it should leave the block.
  typedef struct packed {
    logic [bs4_pkg::OFF_W-1:0]  offset;
    logic [bs4_pkg::WORD_W-1:0] word;
    logic                       last;
  } plane_result_t;

  plane_result_t              planes_due[$];
  logic [bs4_pkg::CFG_W-1:0]  count_reg;
  logic [bs4_pkg::ELEM_W-1:0] group_elems [bs4_pkg::GROUP_SIZE];
  int unsigned                block_pos;
  int                         error_count = 0;

  assign mismatches_o = error_count;

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    error_count++;
  endtask

  // Stores one element and, when it completes a group, queues the 32 plane
  // words that the group must produce.
  task automatic transpose_element(input logic [bs4_pkg::ELEM_W-1:0] value);
    int unsigned   block_len;
    int unsigned   slot;
    int unsigned   grp;
    int unsigned   stride;
    plane_result_t res;
    block_len = 32'(count_reg & 13'h1FF0);
    if (block_len == 0) begin
      block_len = bs4_pkg::GROUP_SIZE;
    end
    if (block_len > MAX_ELEMS) begin
      block_len = MAX_ELEMS;
    end
    slot = block_pos % bs4_pkg::GROUP_SIZE;
    grp  = block_pos / bs4_pkg::GROUP_SIZE;
    group_elems[slot] = value;
    if (slot == bs4_pkg::GROUP_SIZE - 1) begin
      stride = block_len / 8;
      for (int p = 0; p < bs4_pkg::NUM_PLANES; p++) begin
        for (int e = 0; e < bs4_pkg::GROUP_SIZE; e++) begin
          res.word[e] = group_elems[e][p];
        end
        res.offset = bs4_pkg::OFF_W'(p * stride + 2 * grp);
        res.last   = (p == bs4_pkg::NUM_PLANES - 1);
        planes_due.push_back(res);
      end
    end
    block_pos++;
    if (block_pos >= block_len) begin
      block_pos = 0;
    end
  endtask

  // Follows register writes and both channels, and compares every output
  // transaction against the oldest predicted word.
  always @(posedge clk_i or negedge rst_ni) begin
    plane_result_t want;
    if (!rst_ni) begin
      count_reg = 13'd16;
      block_pos = 0;
      planes_due.delete();
      foreach (group_elems[i]) begin
        group_elems[i] = '0;
      end
      pending_o <= 0;
    end else begin
      if (num_elements_we_i) begin
        count_reg = num_elements_i;
      end
      if (in_valid_i && !in_stall_i) begin
        transpose_element(element_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (planes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word: offset 0x%0h word 0x%0h last %0b",
                                    dest_offset_i, plane_word_i, last_i));
        end else begin
          want = planes_due.pop_front();
          if (dest_offset_i !== want.offset) begin
            report_mismatch($sformatf("dest_offset: got 0x%0h, expected 0x%0h",
                                      dest_offset_i, want.offset));
          end
          if (plane_word_i !== want.word) begin
            report_mismatch($sformatf("plane_word at offset 0x%0h: got 0x%0h, expected 0x%0h",
                                      want.offset, plane_word_i, want.word));
          end
          if (last_i !== want.last) begin
            report_mismatch($sformatf("last at offset 0x%0h: got %0b, expected %0b",
                                      want.offset, last_i, want.last));
          end
        end
      end
      pending_o <= planes_due.size();
    end
  end

endmodule

[verif/bitshuffle_4byte_elements_core_tb.sv]
`timescale 1ns / 1ps

module bitshuffle_4byte_elements_core_tb;

  localparam int MAX_ELEMS     = 4096;
  localparam int IDLE_LIMIT    = 4000;
  localparam int RANDOM_ITEMS  = 150;
  localparam int SETTLE_CYCLES = 4;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       cfg_we    = 1'b0;
  logic [bs4_pkg::CFG_W-1:0]  cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic [bs4_pkg::ELEM_W-1:0] element   = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [bs4_pkg::OFF_W-1:0]  dest_offset;
  logic [bs4_pkg::WORD_W-1:0] plane_word;
  logic                       last;
  int                         pending;
  int                         mismatches;
  int                         burst_left  = 0;
  int                         idle_cycles = 0;
  stall_mode_e                stall_mode  = STALL_NONE;
  int                         stall_hold  = 0;
  logic [2:0]                 stall_tick  = '0;

  // Corner elements for the first group: all zeros, all ones, alternating
  // bits, single bits at both ends and assorted byte patterns.
  logic [bs4_pkg::ELEM_W-1:0] corner_elems [bs4_pkg::GROUP_SIZE] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
    32'h0000_0001, 32'h8000_0000, 32'h0000_FFFF, 32'hFFFF_0000,
    32'h00FF_00FF, 32'hFF00_FF00, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
    32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFE, 32'hFFFF_FFFF
  };

  // Register settings visited in order before random settings take over.
  logic [bs4_pkg::CFG_W-1:0] count_settings [8] = '{
    13'd0, 13'd16, 13'd4096, 13'd15, 13'd48, 13'd4095, 13'd33, 13'd8176
  };

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bitshuffle_4byte_elements_core #(
    .MAX_ELEMS(MAX_ELEMS)
  ) dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .num_elements_we_i (cfg_we),
    .num_elements_i    (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .element_i         (element),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .dest_offset_o     (dest_offset),
    .plane_word_o      (plane_word),
    .last_o            (last)
  );

  bitshuffle_plane_monitor #(
    .MAX_ELEMS(MAX_ELEMS)
  ) plane_mon (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .num_elements_we_i (cfg_we),
    .num_elements_i    (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .element_i         (element),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .dest_offset_i     (dest_offset),
    .plane_word_i      (plane_word),
    .last_i            (last),
    .pending_o         (pending),
    .mismatches_o      (mismatches)
  );

  // The receiver switches at random between stall patterns.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 3'd1;
    if (stall_hold == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_hold <= $urandom_range(16, 96);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_COIN:  out_stall <= 1'($urandom_range(0, 1));
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= stall_tick[2];
    endcase
  end

  // Ends the run when no transaction has happened for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sends one element; a new burst starts after a random gap, which may be zero. Valid stays
  // high after the transaction so that the next call can follow at once.
  task automatic push_element(input logic [bs4_pkg::ELEM_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    element  <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // Stops sending and waits until every predicted word has come out. The
  // first edge lets the count from the last input transaction land.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the element count register once the block is idle.
  task automatic write_count(input logic [bs4_pkg::CFG_W-1:0] value);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    int                         sent;
    int                         phase;
    int                         n_items;
    logic [bs4_pkg::ELEM_W-1:0] value;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One full group of corner values at the reset count of 16.
    foreach (corner_elems[i]) begin
      push_element(corner_elems[i]);
    end

    // A count above the maximum, then a partial group that later settings
    // interrupt in the middle of the block.
    write_count(13'h1FFF);
    for (int i = 0; i < 8; i++) begin
      push_element(32'h0000_000F << (4 * i));
    end

    // Random phases, each under its own register setting.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase < $size(count_settings)) begin
        write_count(count_settings[phase]);
      end else begin
        write_count(bs4_pkg::CFG_W'($urandom_range(0, 8191)));
      end
      n_items = $urandom_range(8, 32);
      repeat (n_items) begin
        case ($urandom_range(0, 5))
          0:       value = '0;
          1:       value = '1;
          2:       value = 32'h1 << $urandom_range(0, 31);
          3:       value = ~(32'h1 << $urandom_range(0, 31));
          default: value = $urandom();
        endcase
        push_element(value);
      end
      sent += n_items;
      phase++;
    end

    settle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
